FILE: hw/rtl/cdtes_pkg.sv
// shared types, constants and the month table for the date to epoch seconds block
`default_nettype none

package cdtes_pkg;

  // sequencer steps
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LEAP,
    S_YEAR,
    S_MON,
    S_DAYS,
    S_SEC,
    S_HR,
    S_MIN,
    S_LAST,
    S_DONE
  } state_t;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int OFF_W   = 5;
  localparam int OUT_W   = 39;

  // shared multiplier operand widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // floor(x / 100) = (x * 5243) >> 19, exact for every 14-bit x
  localparam int Q100_W      = 8;
  localparam int RECIP_SHIFT = 19;
  localparam logic signed [MUL_B_W-1:0] RECIP_100 = 18'sd5243;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1970;
  // leap years in 1..1969
  localparam logic [12:0] LEAPS_BEFORE_EPOCH = 13'd477;

  localparam logic [FIELD_W-1:0] FIRST_EXTRA_MONTH = 7'd13;
  localparam logic [FIELD_W-1:0] FEBRUARY          = 7'd2;

  localparam logic signed [MUL_B_W-1:0] DAYS_PER_YEAR = 18'sd365;
  localparam logic signed [MUL_B_W-1:0] LONG_MONTH    = 18'sd31;
  localparam logic signed [MUL_B_W-1:0] SECS_PER_DAY  = 18'sd86400;
  localparam logic signed [MUL_B_W-1:0] SECS_PER_HOUR = 18'sd3600;
  localparam logic signed [MUL_B_W-1:0] SECS_PER_MIN  = 18'sd60;

  localparam logic signed [OFF_W-1:0] OFFSET_RESET = 5'sd9;

  // days in months before month m of a common year, months 13 and up cap at a full year
  function automatic logic [8:0] cum_days(input logic [FIELD_W-1:0] m);
    logic [8:0] d;
    case (m)
      7'd0, 7'd1: d = 9'd0;
      7'd2:       d = 9'd31;
      7'd3:       d = 9'd59;
      7'd4:       d = 9'd90;
      7'd5:       d = 9'd120;
      7'd6:       d = 9'd151;
      7'd7:       d = 9'd181;
      7'd8:       d = 9'd212;
      7'd9:       d = 9'd243;
      7'd10:      d = 9'd273;
      7'd11:      d = 9'd304;
      7'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/calendar_date_to_epoch_seconds_top.sv
// date and time to signed epoch seconds, one shared multiplier and adder under a sequencer
//
//   channel   signals                                        dir
//   input     in_valid, in_ready, year..second               in
//   output    out_valid, out_ready, epoch_seconds            out
//   config    cfg_we, local_offset_hours                     in
//
// out_valid rises once an accepted word has run through the steps div, leap, year, mon,
// days, sec, hr, min and last, one word at a time; with out_ready high the block returns
// to idle and the next word can be accepted. the steps run through the single 25x18 multiplier
// and the single 39-bit accumulator adder.
// in_ready is high only while idle; the result holds until out_ready.
// rst is synchronous; the offset register resets to 9.
`default_nettype none

module calendar_date_to_epoch_seconds_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic signed [cdtes_pkg::OFF_W-1:0]    local_offset_hours,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [cdtes_pkg::YEAR_W-1:0]          year,
  input  wire logic [cdtes_pkg::FIELD_W-1:0]         month,
  input  wire logic [cdtes_pkg::FIELD_W-1:0]         day,
  input  wire logic [cdtes_pkg::FIELD_W-1:0]         hour,
  input  wire logic [cdtes_pkg::FIELD_W-1:0]         minute,
  input  wire logic [cdtes_pkg::FIELD_W-1:0]         second,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [cdtes_pkg::OUT_W-1:0]         epoch_seconds
);

  cdtes_pkg::state_t state, state_next;

  logic signed [cdtes_pkg::OFF_W-1:0]   off;
  logic [cdtes_pkg::YEAR_W-1:0]         yr;
  logic [cdtes_pkg::FIELD_W-1:0]        mon, dy, hr, mn, sc;
  logic                                 leap;
  logic signed [cdtes_pkg::OUT_W-1:0]   acc, acc_next;
  logic signed [cdtes_pkg::OUT_W-1:0]   prod;

  logic signed [cdtes_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cdtes_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cdtes_pkg::MUL_P_W-1:0] mul_full;

  logic [cdtes_pkg::Q100_W-1:0]         q100, q100m1;
  logic [14:0]                          q100_x100;
  logic [cdtes_pkg::YEAR_W-1:0]         rem, ym1, yd;
  logic                                 rem_zero, is_leap, year_after;
  logic [12:0]                          leaps_m1, leap_days;
  logic [cdtes_pkg::FIELD_W-1:0]        mext;
  logic signed [11:0]                   day_add;

  wire in_acc  = in_valid & in_ready;
  wire out_acc = out_valid & out_ready;

  // offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      off <= cdtes_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      off <= local_offset_hours;
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      yr  <= year;
      mon <= month;
      dy  <= day;
      hr  <= hour;
      mn  <= minute;
      sc  <= second;
    end
  end

  // year split: quotient and remainder by 100, leap count below the year, leap flag and day terms
  always_comb begin
    q100       = prod[cdtes_pkg::RECIP_SHIFT +: cdtes_pkg::Q100_W];
    q100_x100  = 15'(q100) * 15'd100;
    rem        = yr - q100_x100[cdtes_pkg::YEAR_W-1:0];
    rem_zero   = (rem == '0);
    ym1        = yr - 14'd1;
    q100m1     = q100 - cdtes_pkg::Q100_W'(rem_zero);
    leaps_m1   = 13'(ym1[cdtes_pkg::YEAR_W-1:2]) - 13'(q100m1) + 13'(q100m1[7:2]);
    leap_days  = leaps_m1 - cdtes_pkg::LEAPS_BEFORE_EPOCH;
    is_leap    = (yr[1:0] == 2'b00) && (!rem_zero || (q100[1:0] == 2'b00));
    year_after = (yr > cdtes_pkg::EPOCH_YEAR);
    yd         = yr - cdtes_pkg::EPOCH_YEAR;
    mext       = (mon > cdtes_pkg::FIRST_EXTRA_MONTH) ? (mon - cdtes_pkg::FIRST_EXTRA_MONTH)
                                                      : '0;
    day_add    = $signed({3'b000, cdtes_pkg::cum_days(mon)})
               + $signed({11'd0, leap && (mon > cdtes_pkg::FEBRUARY)})
               + $signed({5'd0, dy}) - 12'sd1;
  end

  // shared multiplier
  assign mul_full = mul_a * mul_b;

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdtes_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next step
  always_comb begin
    state_next = state;
    case (state)
      cdtes_pkg::S_IDLE: if (in_acc) state_next = cdtes_pkg::S_DIV;
      cdtes_pkg::S_DIV:  state_next = cdtes_pkg::S_LEAP;
      cdtes_pkg::S_LEAP: state_next = cdtes_pkg::S_YEAR;
      cdtes_pkg::S_YEAR: state_next = cdtes_pkg::S_MON;
      cdtes_pkg::S_MON:  state_next = cdtes_pkg::S_DAYS;
      cdtes_pkg::S_DAYS: state_next = cdtes_pkg::S_SEC;
      cdtes_pkg::S_SEC:  state_next = cdtes_pkg::S_HR;
      cdtes_pkg::S_HR:   state_next = cdtes_pkg::S_MIN;
      cdtes_pkg::S_MIN:  state_next = cdtes_pkg::S_LAST;
      cdtes_pkg::S_LAST: state_next = cdtes_pkg::S_DONE;
      cdtes_pkg::S_DONE: if (out_acc) state_next = cdtes_pkg::S_IDLE;
      default:           state_next = cdtes_pkg::S_IDLE;
    endcase
  end

  // operand selection and accumulator update per step
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    acc_next  = acc;
    case (state)
      cdtes_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      cdtes_pkg::S_DIV: begin
        mul_a = $signed({11'd0, yr});
        mul_b = cdtes_pkg::RECIP_100;
      end
      cdtes_pkg::S_LEAP: begin
        mul_a    = year_after ? $signed({11'd0, yd}) : '0;
        mul_b    = cdtes_pkg::DAYS_PER_YEAR;
        acc_next = year_after ? $signed({26'd0, leap_days}) : '0;
      end
      cdtes_pkg::S_YEAR: begin
        mul_a    = $signed({18'd0, mext});
        mul_b    = cdtes_pkg::LONG_MONTH;
        acc_next = acc + prod;
      end
      cdtes_pkg::S_MON: begin
        acc_next = acc + prod;
      end
      cdtes_pkg::S_DAYS: begin
        acc_next = acc + cdtes_pkg::OUT_W'(day_add);
      end
      cdtes_pkg::S_SEC: begin
        mul_a    = acc[cdtes_pkg::MUL_A_W-1:0];
        mul_b    = cdtes_pkg::SECS_PER_DAY;
        acc_next = $signed({32'd0, sc});
      end
      cdtes_pkg::S_HR: begin
        mul_a    = cdtes_pkg::MUL_A_W'($signed({2'b00, hr}) - 9'(off));
        mul_b    = cdtes_pkg::SECS_PER_HOUR;
        acc_next = acc + prod;
      end
      cdtes_pkg::S_MIN: begin
        mul_a    = $signed({18'd0, mn});
        mul_b    = cdtes_pkg::SECS_PER_MIN;
        acc_next = acc + prod;
      end
      cdtes_pkg::S_LAST: begin
        acc_next = acc + prod;
      end
      cdtes_pkg::S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc  <= acc_next;
    prod <= mul_full[cdtes_pkg::OUT_W-1:0];
    if (state == cdtes_pkg::S_LEAP) begin
      leap <= is_leap;
    end
  end

  assign epoch_seconds = acc;

  // one word at a time: never ready while a result waits
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while result pending");

  // an accepted word starts the division step
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == cdtes_pkg::S_DIV))
    else $error("sequencer did not start after accept");

  // reciprocal division leaves a remainder below 100
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (state == cdtes_pkg::S_LEAP) |-> (rem < 14'd100))
    else $error("year remainder out of range");

  // a delivered result returns the block to idle
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    out_acc |=> in_ready)
    else $error("not idle after result taken");

endmodule

`default_nettype wire
